[hw/rtl/oscillation_midpoint_tracker_assert.svh]
// Assertion macros used by omt_core, the oscillation midpoint tracker core
`ifndef OSCILLATION_MIDPOINT_TRACKER_ASSERT_SVH
`define OSCILLATION_MIDPOINT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset
`define OMT_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);
// Check that a condition implies another in the same cycle
`define OMT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition implies another in the next cycle
`define OMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OMT_ASSERT_HOLDS(label, expr, msg)
`define OMT_ASSERT_IMPLIES(label, ante, cons, msg)
`define OMT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/omt_pkg.sv]
// Types and constants of the oscillation midpoint tracker
`timescale 1ns / 1ps
package omt_pkg;

    localparam int ANGLE_W  = 17;
    localparam int CORR_W   = 18;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((ANGLE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CORR_W + ANGLE_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 2'd2;

    // Reset values of the configuration registers
    localparam logic signed [ANGLE_W-1:0] WINDOW_HIGH_RST = 17'sd1280;
    localparam logic signed [ANGLE_W-1:0] WINDOW_LOW_RST  = -17'sd1280;
    localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST = 16'd100;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] window_high;
        logic signed [ANGLE_W-1:0] window_low;
        logic [LIMIT_W-1:0]        sample_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [CORR_W-1:0]  corrected_angle;
        logic signed [ANGLE_W-1:0] offset_now;
        logic                      offset_updated;
    } result_t;

endpackage

[hw/rtl/omt_cfg.sv]
// Configuration register file of the oscillation midpoint tracker
`timescale 1ns / 1ps
module omt_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [omt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [omt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output omt_pkg::cfg_t                     cfg
);
    import omt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // Decode the write transaction; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW_HIGH:  cfg_next.window_high = $signed(cfg_data[ANGLE_W-1:0]);
                CFG_WINDOW_LOW:   cfg_next.window_low = $signed(cfg_data[ANGLE_W-1:0]);
                CFG_SAMPLE_LIMIT: cfg_next.sample_limit = cfg_data[LIMIT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_high  <= WINDOW_HIGH_RST;
            cfg_reg.window_low   <= WINDOW_LOW_RST;
            cfg_reg.sample_limit <= SAMPLE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/omt_core.sv]
// Tracking state and per-sample midpoint update of the oscillation midpoint tracker
`timescale 1ns / 1ps
`include "oscillation_midpoint_tracker_assert.svh"
module omt_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic signed [omt_pkg::ANGLE_W-1:0]  angle,
    input  omt_pkg::cfg_t                       cfg,
    output omt_pkg::result_t                    res
);
    import omt_pkg::*;

    logic signed [ANGLE_W-1:0] high_reg, high_next;
    logic signed [ANGLE_W-1:0] low_reg, low_next;
    logic                      high_valid_reg, high_valid_next;
    logic                      low_valid_reg, low_valid_next;
    logic [LIMIT_W-1:0]        count_reg, count_next;
    logic signed [ANGLE_W-1:0] midpoint_reg, midpoint_next;
    logic                      saw_pos_reg, saw_pos_next;
    logic                      saw_neg_reg, saw_neg_next;

    logic                      in_window;
    logic signed [ANGLE_W-1:0] cap_high, cap_low;
    logic                      cap_high_valid, cap_low_valid;
    logic                      tracking;
    logic signed [ANGLE_W-1:0] sort_high, sort_low;
    logic signed [ANGLE_W-1:0] wide_high, wide_low;
    logic                      limit_hit;
    logic signed [CORR_W-1:0]  extreme_sum;
    logic signed [ANGLE_W-1:0] midpoint_new;
    logic signed [ANGLE_W-1:0] midpoint_use;
    logic signed [CORR_W-1:0]  corr;
    logic                      pos_base, neg_base;

    assign in_window = (angle < cfg.window_high) && (angle > cfg.window_low);

    // Capture the first, then the second extreme once both signs were seen
    always_comb begin
        cap_high       = high_reg;
        cap_low        = low_reg;
        cap_high_valid = high_valid_reg;
        cap_low_valid  = low_valid_reg;
        if (in_window && saw_pos_reg && saw_neg_reg) begin
            if (!high_valid_reg) begin
                cap_high       = angle;
                cap_high_valid = 1'b1;
            end else if (!low_valid_reg) begin
                cap_low       = angle;
                cap_low_valid = 1'b1;
            end
        end
    end

    // Order the pair and widen it by this sample
    assign tracking  = in_window && cap_high_valid && cap_low_valid;
    assign sort_high = (cap_high < cap_low) ? cap_low : cap_high;
    assign sort_low  = (cap_high < cap_low) ? cap_high : cap_low;
    assign wide_high = (angle > sort_high) ? angle : sort_high;
    assign wide_low  = (angle < sort_low) ? angle : sort_low;
    assign limit_hit = tracking && (count_reg >= cfg.sample_limit);

    // Floor of the mean: arithmetic shift of the widened sum
    assign extreme_sum  = {wide_low[ANGLE_W-1], wide_low} + {wide_high[ANGLE_W-1], wide_high};
    assign midpoint_new = extreme_sum[CORR_W-1:1];
    assign midpoint_use = limit_hit ? midpoint_new : midpoint_reg;
    assign corr = {angle[ANGLE_W-1], angle} - {midpoint_use[ANGLE_W-1], midpoint_use};

    // Next tracking state
    always_comb begin
        midpoint_next = midpoint_use;
        if (limit_hit) begin
            high_next       = '0;
            low_next        = '0;
            high_valid_next = 1'b0;
            low_valid_next  = 1'b0;
            count_next      = '0;
        end else if (tracking) begin
            high_next       = wide_high;
            low_next        = wide_low;
            high_valid_next = 1'b1;
            low_valid_next  = 1'b1;
            count_next      = count_reg + 16'd1;
        end else begin
            high_next       = cap_high;
            low_next        = cap_low;
            high_valid_next = cap_high_valid;
            low_valid_next  = cap_low_valid;
            count_next      = count_reg;
        end
    end

    // Sign flags: an update clears them first, a zero correction clears both
    always_comb begin
        pos_base = limit_hit ? 1'b0 : saw_pos_reg;
        neg_base = limit_hit ? 1'b0 : saw_neg_reg;
        priority if (corr == '0) begin
            saw_pos_next = 1'b0;
            saw_neg_next = 1'b0;
        end else if (corr[CORR_W-1]) begin
            saw_pos_next = pos_base;
            saw_neg_next = 1'b1;
        end else begin
            saw_pos_next = 1'b1;
            saw_neg_next = neg_base;
        end
    end

    // Advance the state on each processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg       <= '0;
            low_reg        <= '0;
            high_valid_reg <= 1'b0;
            low_valid_reg  <= 1'b0;
            count_reg      <= '0;
            midpoint_reg   <= '0;
            saw_pos_reg    <= 1'b0;
            saw_neg_reg    <= 1'b0;
        end else if (step) begin
            high_reg       <= high_next;
            low_reg        <= low_next;
            high_valid_reg <= high_valid_next;
            low_valid_reg  <= low_valid_next;
            count_reg      <= count_next;
            midpoint_reg   <= midpoint_next;
            saw_pos_reg    <= saw_pos_next;
            saw_neg_reg    <= saw_neg_next;
        end
    end

    assign res.corrected_angle = corr;
    assign res.offset_now      = midpoint_use;
    assign res.offset_updated  = limit_hit;

    `OMT_ASSERT_IMPLIES(a_low_needs_high, low_valid_reg, high_valid_reg, "low extreme valid alone")
    `OMT_ASSERT_IMPLIES(a_count_needs_pair, count_reg != '0, high_valid_reg && low_valid_reg, "count without extremes")
    `OMT_ASSERT_NEXT(a_update_clears, step && limit_hit, !high_valid_reg && (count_reg == '0), "update left tracking state")
    `OMT_ASSERT_IMPLIES(a_midpoint_only_on_update, !$stable(midpoint_reg), $past(step && limit_hit), "midpoint moved without update")

endmodule

[hw/rtl/oscillation_midpoint_tracker.sv]
// A sample in the input register moves into the result register, and so onto
// m_tdata, once that one is free or read. Throughput: one sample per cycle while
// m_tready stays high; the omt_core state update closes the loop between samples.
// The input register accepts while a result waits, as long as it moves on.
// Reset (aresetn low, synchronous) empties both stages, clears the tracking
// state and midpoint, and loads the register defaults 1280, -1280 and 100.
`timescale 1ns / 1ps
module oscillation_midpoint_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [omt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [omt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input samples
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [omt_pkg::S_TDATA_W-1:0]    s_tdata,  // [16:0] tilt_angle, rest zero
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [omt_pkg::M_TDATA_W-1:0]    m_tdata,  // [17:0] corrected_angle, [34:18] offset_now, rest zero
    output logic                             m_tuser   // [0] offset_updated
);
    import omt_pkg::*;

    cfg_t    cfg;
    result_t res;

    logic                      in_vld_reg, in_vld_next;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic                      out_vld_reg, out_vld_next;
    result_t                   out_res_reg;
    logic                      s_accept;
    logic                      advance;

    omt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    omt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .angle   (in_angle_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Move the held sample into the result register when that one is free or being read
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold payloads
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_angle_reg <= $signed(s_tdata[ANGLE_W-1:0]);
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       out_res_reg.offset_now, out_res_reg.corrected_angle};
    assign m_tuser  = out_res_reg.offset_updated;

endmodule

[tb/omt_midpoint_checker.sv]
// Checker for the oscillation midpoint tracker: predicts every result and compares it
`timescale 1ns / 1ps
module omt_midpoint_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [omt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [omt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [omt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [omt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tuser,
    output int                             mismatches,
    output int                             outstanding
);
    import omt_pkg::*;

    localparam int MAX_REPORTS = 20;

    // Shadow copy of the configuration registers
    logic signed [ANGLE_W-1:0] win_high;
    logic signed [ANGLE_W-1:0] win_low;
    logic [LIMIT_W-1:0]        limit;

    // Shadow copy of the tracking state
    logic signed [ANGLE_W-1:0] ext_hi;
    logic signed [ANGLE_W-1:0] ext_lo;
    logic                      hi_ok;
    logic                      lo_ok;
    logic [LIMIT_W-1:0]        track_cnt;
    logic signed [ANGLE_W-1:0] midpoint;
    logic                      saw_pos;
    logic                      saw_neg;

    result_t predicted_corrections[$];
    result_t got;
    result_t want;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic flag_mismatch(input string what, input int got_v, input int exp_v);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got_v, exp_v);
        mismatches++;
    endtask

    task automatic clear_model();
        win_high  = WINDOW_HIGH_RST;
        win_low   = WINDOW_LOW_RST;
        limit     = SAMPLE_LIMIT_RST;
        ext_hi    = '0;
        ext_lo    = '0;
        hi_ok     = 1'b0;
        lo_ok     = 1'b0;
        track_cnt = '0;
        midpoint  = '0;
        saw_pos   = 1'b0;
        saw_neg   = 1'b0;
        predicted_corrections.delete();
    endtask

    // Advance the tracker by one sample and queue the result it must produce
    task automatic track_sample(input logic signed [ANGLE_W-1:0] angle);
        logic signed [CORR_W-1:0]  corr;
        logic signed [ANGLE_W:0]   pair_sum;
        logic signed [ANGLE_W-1:0] held;
        logic                      updated;
        result_t                   r;
        updated = 1'b0;
        if (angle < win_high && angle > win_low) begin
            // capture extremes only once the swing has crossed the midpoint both ways
            if (saw_pos && saw_neg) begin
                if (!hi_ok) begin
                    ext_hi = angle;
                    hi_ok  = 1'b1;
                end else if (!lo_ok) begin
                    ext_lo = angle;
                    lo_ok  = 1'b1;
                end
            end
            if (hi_ok && lo_ok) begin
                if (ext_hi < ext_lo) begin
                    held   = ext_hi;
                    ext_hi = ext_lo;
                    ext_lo = held;
                end
                if (angle < ext_lo)
                    ext_lo = angle;
                if (angle > ext_hi)
                    ext_hi = angle;
                if (track_cnt >= limit) begin
                    // new midpoint: floor of the mean, then restart tracking
                    pair_sum  = ext_lo + ext_hi;
                    midpoint  = pair_sum[ANGLE_W:1];
                    track_cnt = '0;
                    hi_ok     = 1'b0;
                    lo_ok     = 1'b0;
                    ext_hi    = '0;
                    ext_lo    = '0;
                    saw_pos   = 1'b0;
                    saw_neg   = 1'b0;
                    updated   = 1'b1;
                end else begin
                    track_cnt = track_cnt + 1'b1;
                end
            end
        end
        corr = angle - midpoint;
        if (corr > 0) begin
            saw_pos = 1'b1;
        end else if (corr < 0) begin
            saw_neg = 1'b1;
        end else begin
            saw_pos = 1'b0;
            saw_neg = 1'b0;
        end
        r.corrected_angle = corr;
        r.offset_now      = midpoint;
        r.offset_updated  = updated;
        predicted_corrections.push_back(r);
    endtask

    // Watch all three channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            // apply register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_HIGH:  win_high = cfg_data[ANGLE_W-1:0];
                    CFG_WINDOW_LOW:   win_low  = cfg_data[ANGLE_W-1:0];
                    CFG_SAMPLE_LIMIT: limit    = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.corrected_angle = m_tdata[CORR_W-1:0];
                got.offset_now      = m_tdata[M_FIELDS_W-1:CORR_W];
                got.offset_updated  = m_tuser;
                if (predicted_corrections.size() == 0) begin
                    flag_mismatch("result with nothing expected, corrected_angle",
                                  got.corrected_angle, 0);
                end else begin
                    want = predicted_corrections.pop_front();
                    if (got.corrected_angle !== want.corrected_angle)
                        flag_mismatch("corrected_angle", got.corrected_angle,
                                      want.corrected_angle);
                    if (got.offset_now !== want.offset_now)
                        flag_mismatch("offset_now", got.offset_now, want.offset_now);
                    if (got.offset_updated !== want.offset_updated)
                        flag_mismatch("offset_updated", got.offset_updated,
                                      want.offset_updated);
                end
            end
            // predict each accepted sample transaction
            if (s_tvalid && s_tready)
                track_sample(s_tdata[ANGLE_W-1:0]);
        end
        outstanding = predicted_corrections.size();
    end

endmodule

[tb/oscillation_midpoint_tracker_tb.sv]
// Stimulus and verdict for the oscillation midpoint tracker
`timescale 1ns / 1ps
module oscillation_midpoint_tracker_tb;
    import omt_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    localparam int ANGLE_MAX   = 46080;
    localparam int HOLD_CYCLES = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    int   mismatches;
    int   outstanding;
    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    logic hold_start     = 1'b0;
    int   hold_left      = 0;
    int   cur_high;
    int   cur_low;
    int   script[$];

    oscillation_midpoint_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    omt_midpoint_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Drive the result-side ready: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_start) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_gap_pct   = 67;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_gap_pct   = 0;
                recv_stall_pct = 67;
            end
            default: begin
                send_gap_pct   = 20;
                recv_stall_pct = 20;
            end
        endcase
    endtask

    // Stop offering samples and wait until every result is back
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // One register write transaction; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WINDOW_HIGH: cur_high = $signed(data);
            CFG_WINDOW_LOW:  cur_low  = $signed(data);
            default: ;
        endcase
    endtask

    task automatic configure(input int high, input int low, input int lim,
                             input bit poke_unused = 1'b0);
        drain();
        write_reg(CFG_WINDOW_HIGH, ANGLE_W'(high));
        write_reg(CFG_WINDOW_LOW, ANGLE_W'(low));
        // the bit above the limit field is ignored, so toggle it freely
        write_reg(CFG_SAMPLE_LIMIT, {1'($urandom_range(1)), LIMIT_W'(lim)});
        if (poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // One sample transaction, preceded by random idle cycles
    task automatic send_angle(input int angle);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - ANGLE_W){1'b0}}, ANGLE_W'(angle)};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_script();
        foreach (script[i])
            send_angle(script[i]);
    endtask

    // Mostly in-window swings, with window edges and full-range noise mixed in
    function automatic int pick_angle(input int in_pct);
        int span;
        span = cur_high - cur_low - 1;
        if (span > 0 && $urandom_range(99) < in_pct) begin
            case ($urandom_range(19))
                0:       return cur_low + 1;
                1:       return cur_high - 1;
                default: return cur_low + 1 + int'($urandom_range(span - 1));
            endcase
        end
        case ($urandom_range(9))
            0:       return cur_high;
            1:       return cur_low;
            2:       return ANGLE_MAX;
            3:       return -ANGLE_MAX;
            default: return -ANGLE_MAX + int'($urandom_range(2 * ANGLE_MAX));
        endcase
    endfunction

    task automatic run_phase(input int high, input int low, input int lim,
                             input idle_mode_e mode, input int count, input int in_pct);
        configure(high, low, lim);
        set_idle(mode);
        repeat (count)
            send_angle(pick_angle(in_pct));
    endtask

    initial begin
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_WINDOW_HIGH;
        cfg_data   <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cur_high   = 1280;
        cur_low    = -1280;
        set_idle(IDLE_NONE);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: largest test angles, window edges, zero correction, start of tracking
        script = '{-46080, 46080, 0, 1279, 1280, -1280, -1279, 300, -200, 150};
        send_script();

        // Zero limit: update on the first sample with both extremes held
        configure(1280, -1280, 0);
        script = '{400, -600, 0, -600};
        send_script();

        // Limit lowered while tracking: update on the next tracked sample
        configure(1280, -1280, 65535);
        script = '{100, -100, 50, -50, -20};
        send_script();
        configure(1280, -1280, 1);
        script = '{20, 30, -40};
        send_script();

        // Empty window, plus a write to an index past the register list
        configure(-100, 100, 5, 1'b1);
        script = '{0, 50, -50};
        send_script();

        // Random part; a long receiver hold-off while samples keep coming
        run_phase(1280, -1280, 3, IDLE_NONE, 40, 90);
        s_tvalid   <= 1'b0;
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        repeat (40)
            send_angle(pick_angle(90));

        run_phase(512, -512, 0, IDLE_SENDER, 60, 90);

        // Widest window, with a sender pause until all results are back
        run_phase(ANGLE_MAX, -ANGLE_MAX, 10, IDLE_RECEIVER, 40, 85);
        drain();
        repeat (40)
            send_angle(pick_angle(85));

        run_phase(200, -900, 1, IDLE_BOTH, 60, 90);
        run_phase(-ANGLE_MAX, ANGLE_MAX, 5, IDLE_NONE, 40, 50);
        run_phase(3000, -3000, 65535, IDLE_SENDER, 50, 90);
        run_phase(20, -20, 2, IDLE_RECEIVER, 60, 90);
        run_phase(1280, -1280, 7, IDLE_BOTH, 80, 90);
        run_phase(-300, -2000, 4, IDLE_NONE, 60, 90);

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
